### rtl/lfb_pkg.sv
// shared types, constants and helpers for the landmark frame builder
package lfb_pkg;

  // normalizer timing: magnitude, lead detect, scale, square, sum,
  // one root bit per stage, numerator, one quotient bit per stage, sign
  localparam int unsigned RootSteps = 32;
  localparam int unsigned QuoSteps  = 31;
  localparam int unsigned NormLat   = 5 + RootSteps + 1 + QuoSteps + 1;

  // whole datapath: input stage, two normalizers in series, five dot/orthogonalize
  // stages and two cross product stages
  localparam int unsigned PipeDepth = 2 * NormLat + 8;

  localparam logic [31:0] MinSpanRst = 32'd1;
  localparam logic [10:0] YTol       = 11'd1074;
  localparam logic [23:0] YTolSq     = 24'(1074 * 1074);

  typedef enum logic [1:0] {
    ColX   = 2'd0,
    ColY   = 2'd1,
    ColZ   = 2'd2,
    ColOrg = 2'd3
  } col_e;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [33:0] s34_t;
  typedef s32_t [2:0] vec32_t;
  typedef s34_t [2:0] vec34_t;

  typedef struct packed {
    s32_t left_spine_x;
    s32_t left_spine_y;
    s32_t left_spine_z;
    s32_t right_spine_x;
    s32_t right_spine_y;
    s32_t right_spine_z;
    s32_t left_pubic_x;
    s32_t left_pubic_y;
    s32_t left_pubic_z;
    s32_t right_pubic_x;
    s32_t right_pubic_y;
    s32_t right_pubic_z;
  } frame_req_t;

  typedef struct packed {
    logic [1:0] column_index;
    s32_t       comp_first;
    s32_t       comp_second;
    s32_t       comp_third;
    logic       last_column;
    logic       degenerate;
  } frame_col_t;

  // Q4.60 back to Q2.30, halves away from zero
  function automatic logic signed [36:0] rnd30(input logic signed [66:0] v);
    logic [66:0] m;
    logic [66:0] r;
    m = v[66] ? 67'(-v) : 67'(v);
    r = (m + (67'd1 << 29)) >> 30;
    rnd30 = v[66] ? -$signed(r[36:0]) : $signed(r[36:0]);
  endfunction

  // position of the highest set bit
  function automatic logic [5:0] lead34(input logic [33:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

### rtl/lfb_norm.sv
// pipelined vector normalizer: scale, square root and three dividers
module lfb_norm (
  input  logic            clk_i,
  input  logic            en_i,
  input  lfb_pkg::vec34_t vec_i,
  output lfb_pkg::vec32_t unit_o
);

  localparam int unsigned RootSteps = lfb_pkg::RootSteps;
  localparam int unsigned QuoSteps  = lfb_pkg::QuoSteps;

  logic [2:0][33:0] mag_q, mag2_q;
  logic [2:0]       neg_q, neg2_q, neg3_q, neg4_q;
  logic [5:0]       lead_q;
  logic             zero2_q, zero3_q, zero4_q;
  logic [2:0][30:0] sc3_q, sc4_q;
  logic [2:0][61:0] sq_q;
  logic [33:0]      mag_or;

  logic [63:0]      rt_num_q [RootSteps+1];
  logic [63:0]      rt_res_q [RootSteps+1];
  logic [2:0][30:0] rt_sc_q  [RootSteps+1];
  logic [2:0]       rt_neg_q [RootSteps+1];
  logic             rt_zero_q[RootSteps+1];

  logic [2:0][31:0] dv_rem_q [QuoSteps+1];
  logic [2:0][30:0] dv_low_q [QuoSteps+1];
  logic [2:0][30:0] dv_quo_q [QuoSteps+1];
  logic [31:0]      dv_n_q   [QuoSteps+1];
  logic [2:0]       dv_neg_q [QuoSteps+1];
  logic             dv_zero_q[QuoSteps+1];

  lfb_pkg::vec32_t  unit_q;

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

  // magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= vec_i[i][33];
        mag_q[i] <= vec_i[i][33] ? 34'(-vec_i[i]) : 34'(vec_i[i]);
      end
    end
  end

  // leading one of the largest magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lead_q  <= lfb_pkg::lead34(mag_or);
      zero2_q <= ~|mag_or;
      mag2_q  <= mag_q;
      neg2_q  <= neg_q;
    end
  end

  // scale so the largest magnitude lands in [2^30, 2^31)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (lead_q >= 6'd30) begin
          sc3_q[i] <= 31'(mag2_q[i] >> (lead_q - 6'd30));
        end else begin
          sc3_q[i] <= 31'(64'(mag2_q[i]) << (6'd30 - lead_q));
        end
      end
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 62'(sc3_q[i]) * 62'(sc3_q[i]);
      end
      sc4_q   <= sc3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // sum of squares enters the root pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_num_q[0]  <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      rt_res_q[0]  <= 64'd0;
      rt_sc_q[0]   <= sc4_q;
      rt_neg_q[0]  <= neg4_q;
      rt_zero_q[0] <= zero4_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    localparam logic [63:0] RootBit = 64'd1 << (2 * (RootSteps - 1 - j));
    logic [64:0] trial;
    assign trial = {1'b0, rt_res_q[j]} + {1'b0, RootBit};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, rt_num_q[j]} >= trial) begin
          rt_num_q[j+1] <= rt_num_q[j] - trial[63:0];
          rt_res_q[j+1] <= (rt_res_q[j] >> 1) + RootBit;
        end else begin
          rt_num_q[j+1] <= rt_num_q[j];
          rt_res_q[j+1] <= rt_res_q[j] >> 1;
        end
        rt_sc_q[j+1]   <= rt_sc_q[j];
        rt_neg_q[j+1]  <= rt_neg_q[j];
        rt_zero_q[j+1] <= rt_zero_q[j];
      end
    end
  end

  // rounded numerator m * 2^30 + n / 2, split into top and low bits
  always_ff @(posedge clk_i) begin
    logic [31:0] n;
    logic [63:0] num;
    n = rt_res_q[RootSteps][31:0];
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num = (64'(rt_sc_q[RootSteps][i]) << 30) + 64'(n >> 1);
        dv_rem_q[0][i] <= 32'(num[61:31]);
        dv_low_q[0][i] <= num[30:0];
        dv_quo_q[0][i] <= 31'd0;
      end
      dv_n_q[0]    <= n;
      dv_neg_q[0]  <= rt_neg_q[RootSteps];
      dv_zero_q[0] <= rt_zero_q[RootSteps];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QuoSteps; j++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] part;
      logic        ge;
      assign part = {dv_rem_q[j][i], dv_low_q[j][i][30]};
      assign ge   = part >= {1'b0, dv_n_q[j]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_rem_q[j+1][i] <= ge ? 32'(part - {1'b0, dv_n_q[j]}) : part[31:0];
          dv_low_q[j+1][i] <= dv_low_q[j][i] << 1;
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][29:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_n_q[j+1]    <= dv_n_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end
  end

  // sign and zero vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[QuoSteps]) begin
          unit_q[i] <= '0;
        end else if (dv_neg_q[QuoSteps][i]) begin
          unit_q[i] <= 32'(-$signed({1'b0, dv_quo_q[QuoSteps][i]}));
        end else begin
          unit_q[i] <= $signed({1'b0, dv_quo_q[QuoSteps][i]});
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

### rtl/landmark_frame_builder_core.sv
// top level of the landmark frame builder: pipeline and column serializer
// the four result columns of a frame leave in turn through one frame holding
// register; the pipeline takes a request every cycle while the serializer has room
// reset: asynchronous active low, clears valid bits and serializer, sets min_span_q to 1
module landmark_frame_builder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfb_pkg::frame_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfb_pkg::frame_col_t out_data_o
);

  localparam int unsigned NormLat   = lfb_pkg::NormLat;
  localparam int unsigned PipeDepth = lfb_pkg::PipeDepth;

  logic                 en;
  logic [31:0]          min_span_q;
  logic [PipeDepth-1:0] vld_q;

  // input stage
  lfb_pkg::vec32_t  org_q;
  lfb_pkg::vec34_t  d_q, w_q;
  logic [2:0][15:0] spm_q;
  logic             spbig_q;
  logic [33:0]      span_sum;
  logic             deg_span;

  // first delay line and dot product stages
  lfb_pkg::vec32_t  dla_org_q[NormLat];
  logic             dla_deg_q[NormLat];
  lfb_pkg::vec32_t  x_u, y0_u;
  lfb_pkg::vec32_t  x1_q, y01_q, org1_q;
  logic             deg1_q;
  logic signed [2:0][63:0] pp_q;
  lfb_pkg::vec32_t  x2_q, y02_q, org2_q;
  logic             deg2_q;
  logic signed [33:0] dot_q;
  lfb_pkg::vec32_t  x3_q, y03_q, org3_q;
  logic             deg3_q;
  logic signed [2:0][65:0] dp_q;
  lfb_pkg::vec32_t  x4_q, org4_q;
  lfb_pkg::vec34_t  y1_q;
  logic             deg4_q;
  lfb_pkg::vec32_t  x5_q, org5_q;
  lfb_pkg::vec34_t  y15_q;
  logic             deg5_q;

  // second delay line and cross product stages
  lfb_pkg::vec32_t  dlb_x_q[NormLat];
  lfb_pkg::vec32_t  dlb_org_q[NormLat];
  logic             dlb_deg_q[NormLat];
  lfb_pkg::vec32_t  y_u;
  logic signed [5:0][63:0] cp_q;
  lfb_pkg::vec32_t  xc1_q, yc1_q, orgc1_q;
  logic             degc1_q;
  lfb_pkg::vec32_t  xc2_q, yc2_q, zc2_q, orgc2_q;
  logic             degc2_q;

  // serializer
  lfb_pkg::vec32_t  fr_x_q, fr_y_q, fr_z_q, fr_org_q;
  logic             fr_deg_q;
  logic             busy_q;
  lfb_pkg::col_e    col_q;
  lfb_pkg::vec32_t  col_sel;
  logic             load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_span_q <= lfb_pkg::MinSpanRst;
    end else if (cfg_we_i) begin
      min_span_q <= cfg_wdata_i;
    end
  end

  // pipeline advance while the serializer can take the next frame
  assign en         = !busy_q || (out_ready_i && col_q == lfb_pkg::ColOrg);
  assign in_ready_o = en;
  assign load       = en && vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // origin, spine difference and pubic-to-origin vector
  always_ff @(posedge clk_i) begin
    logic [32:0] so [3];
    logic [32:0] sp [3];
    lfb_pkg::s32_t a [3];
    lfb_pkg::s32_t b [3];
    lfb_pkg::s32_t c [3];
    lfb_pkg::s32_t e [3];
    logic signed [33:0] dd;
    logic [33:0] dm;
    logic big;
    a[0] = in_data_i.left_spine_x;   a[1] = in_data_i.left_spine_y;
    a[2] = in_data_i.left_spine_z;
    b[0] = in_data_i.right_spine_x;  b[1] = in_data_i.right_spine_y;
    b[2] = in_data_i.right_spine_z;
    c[0] = in_data_i.left_pubic_x;   c[1] = in_data_i.left_pubic_y;
    c[2] = in_data_i.left_pubic_z;
    e[0] = in_data_i.right_pubic_x;  e[1] = in_data_i.right_pubic_y;
    e[2] = in_data_i.right_pubic_z;
    big = 1'b0;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        so[i] = {a[i][31], a[i]} + {b[i][31], b[i]};
        sp[i] = {c[i][31], c[i]} + {e[i][31], e[i]};
        org_q[i] <= so[i][32:1];
        w_q[i]   <= $signed({so[i][32], so[i][32], so[i][32:1]})
                  - $signed({sp[i][32], sp[i][32], sp[i][32:1]});
        dd = $signed({a[i][31], a[i][31], a[i]}) - $signed({b[i][31], b[i][31], b[i]});
        d_q[i] <= dd;
        dm = dd[33] ? 34'(-dd) : 34'(dd);
        spm_q[i] <= dm[15:0];
        big = big | (|dm[33:16]);
      end
      spbig_q <= big;
    end
  end

  // short span check on the small-magnitude case
  assign span_sum = 34'(32'(spm_q[0]) * 32'(spm_q[0]))
                  + 34'(32'(spm_q[1]) * 32'(spm_q[1]))
                  + 34'(32'(spm_q[2]) * 32'(spm_q[2]));
  assign deg_span = !spbig_q && (span_sum <= {2'b00, min_span_q});

  lfb_norm u_norm_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (d_q),
    .unit_o (x_u)
  );

  lfb_norm u_norm_y0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (w_q),
    .unit_o (y0_u)
  );

  // origin and flag travel beside the first normalizers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dla_org_q[0] <= org_q;
      dla_deg_q[0] <= deg_span;
      for (int k = 1; k < NormLat; k++) begin
        dla_org_q[k] <= dla_org_q[k-1];
        dla_deg_q[k] <= dla_deg_q[k-1];
      end
    end
  end

  // y0 . x products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp_q[i] <= 64'(x_u[i]) * 64'(y0_u[i]);
      end
      x1_q   <= x_u;
      y01_q  <= y0_u;
      org1_q <= dla_org_q[NormLat-1];
      deg1_q <= dla_deg_q[NormLat-1];
    end
  end

  // rounded dot product
  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q  <= 34'(lfb_pkg::rnd30(67'($signed(pp_q[0])) + 67'($signed(pp_q[1]))
                                   + 67'($signed(pp_q[2]))));
      x2_q   <= x1_q;
      y02_q  <= y01_q;
      org2_q <= org1_q;
      deg2_q <= deg1_q;
    end
  end

  // projection products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= 66'(dot_q) * 66'(x2_q[i]);
      end
      x3_q   <= x2_q;
      y03_q  <= y02_q;
      org3_q <= org2_q;
      deg3_q <= deg2_q;
    end
  end

  // remove the x component from y
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y1_q[i] <= 34'(y03_q[i]) - 34'(lfb_pkg::rnd30(67'($signed(dp_q[i]))));
      end
      x4_q   <= x3_q;
      org4_q <= org3_q;
      deg4_q <= deg3_q;
    end
  end

  // vanishing y check
  always_ff @(posedge clk_i) begin
    logic [33:0] ym;
    logic        y_tiny;
    logic [23:0] ysum;
    y_tiny = 1'b1;
    ysum   = 24'd0;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ym     = y1_q[i][33] ? 34'(-y1_q[i]) : 34'(y1_q[i]);
        y_tiny = y_tiny & (ym <= 34'(lfb_pkg::YTol));
        ysum   = ysum + 24'(22'(ym[10:0]) * 22'(ym[10:0]));
      end
      deg5_q <= deg4_q | (y_tiny && ysum <= lfb_pkg::YTolSq);
      y15_q  <= y1_q;
      x5_q   <= x4_q;
      org5_q <= org4_q;
    end
  end

  lfb_norm u_norm_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (y15_q),
    .unit_o (y_u)
  );

  // x, origin and flag travel beside the second normalizer
  always_ff @(posedge clk_i) begin
    if (en) begin
      dlb_x_q[0]   <= x5_q;
      dlb_org_q[0] <= org5_q;
      dlb_deg_q[0] <= deg5_q;
      for (int k = 1; k < NormLat; k++) begin
        dlb_x_q[k]   <= dlb_x_q[k-1];
        dlb_org_q[k] <= dlb_org_q[k-1];
        dlb_deg_q[k] <= dlb_deg_q[k-1];
      end
    end
  end

  // cross product terms
  always_ff @(posedge clk_i) begin
    lfb_pkg::vec32_t xv;
    xv = dlb_x_q[NormLat-1];
    if (en) begin
      cp_q[0] <= 64'(xv[1]) * 64'(y_u[2]);
      cp_q[1] <= 64'(xv[2]) * 64'(y_u[1]);
      cp_q[2] <= 64'(xv[2]) * 64'(y_u[0]);
      cp_q[3] <= 64'(xv[0]) * 64'(y_u[2]);
      cp_q[4] <= 64'(xv[0]) * 64'(y_u[1]);
      cp_q[5] <= 64'(xv[1]) * 64'(y_u[0]);
      xc1_q   <= xv;
      yc1_q   <= y_u;
      orgc1_q <= dlb_org_q[NormLat-1];
      degc1_q <= dlb_deg_q[NormLat-1];
    end
  end

  // z = x cross y
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        zc2_q[i] <= 32'(lfb_pkg::rnd30(67'($signed(cp_q[2*i]))
                                       - 67'($signed(cp_q[2*i+1]))));
      end
      xc2_q   <= xc1_q;
      yc2_q   <= yc1_q;
      orgc2_q <= orgc1_q;
      degc2_q <= degc1_q;
    end
  end

  // frame holding register
  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_x_q   <= xc2_q;
      fr_y_q   <= yc2_q;
      fr_z_q   <= zc2_q;
      fr_org_q <= orgc2_q;
      fr_deg_q <= degc2_q;
    end
  end

  // column sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= lfb_pkg::ColX;
    end else if (load) begin
      busy_q <= 1'b1;
      col_q  <= lfb_pkg::ColX;
    end else if (busy_q && out_ready_i) begin
      if (col_q == lfb_pkg::ColOrg) begin
        busy_q <= 1'b0;
      end else begin
        col_q <= lfb_pkg::col_e'(col_q + 2'd1);
      end
    end
  end

  // column select
  always_comb begin
    unique case (col_q)
      lfb_pkg::ColX:   col_sel = fr_x_q;
      lfb_pkg::ColY:   col_sel = fr_y_q;
      lfb_pkg::ColZ:   col_sel = fr_z_q;
      lfb_pkg::ColOrg: col_sel = fr_org_q;
      default:         col_sel = fr_org_q;
    endcase
  end

  assign out_valid_o             = busy_q;
  assign out_data_o.column_index = col_q;
  assign out_data_o.comp_first   = fr_deg_q ? '0 : col_sel[0];
  assign out_data_o.comp_second  = fr_deg_q ? '0 : col_sel[1];
  assign out_data_o.comp_third   = fr_deg_q ? '0 : col_sel[2];
  assign out_data_o.last_column  = (col_q == lfb_pkg::ColOrg);
  assign out_data_o.degenerate   = fr_deg_q;

endmodule

### rtl/lfb_checker.sv
// port-level checks for the landmark frame builder, bound to the top level
module lfb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lfb_pkg::frame_col_t out_data_o
);

  logic col_done;
  logic mid_frame;

  assign col_done  = out_valid_o && out_ready_i;
  assign mid_frame = col_done && (out_data_o.column_index != lfb_pkg::ColOrg);

  // columns of one frame follow without a gap and in order
  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_frame |=> out_valid_o &&
      out_data_o.column_index == 2'($past(out_data_o.column_index) + 2'd1))
    else $error("column sequence broken");

  // one degenerate flag for the whole frame
  a_deg_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_frame |=> out_data_o.degenerate == $past(out_data_o.degenerate))
    else $error("degenerate flag changed inside a frame");

  // degenerate frames carry zero components
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.comp_first == '0 && out_data_o.comp_second == '0 &&
      out_data_o.comp_third == '0)
    else $error("degenerate column with nonzero components");

  // last marker only on the origin column
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.last_column == (out_data_o.column_index == lfb_pkg::ColOrg))
    else $error("last marker misplaced");

  // a stalled result request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result request dropped or changed under stall");

endmodule

bind landmark_frame_builder_core lfb_checker u_lfb_checker (.*);
